### rtl/cmlw_pkg.sv
// Shared constants and types of the command mailbox liveness watchdog.
package cmlw_pkg;

  localparam int unsigned PAYLOAD_BITS = 64;
  localparam int unsigned PAYLOAD_W    = 64;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned SEQ_W        = 32;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned NUM_CNT      = 7;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [TIME_W-1:0] SHORT_TIMEOUT_RST = 32'd200;
  localparam logic [TIME_W-1:0] LONG_TIMEOUT_RST  = 32'd1200;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG  = 1'd1;

  // Event modes.
  localparam logic [2:0] MODE_POST   = 3'd0;
  localparam logic [2:0] MODE_TICK   = 3'd1;
  localparam logic [2:0] MODE_REJECT = 3'd2;
  localparam logic [2:0] MODE_LATCH  = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;
  localparam logic [2:0] MODE_READ   = 3'd5;

  // Link states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FRESH = 2'd1;
  localparam logic [1:0] ST_HOLD  = 2'd2;
  localparam logic [1:0] ST_RELAX = 2'd3;

  // Event counter indexes.
  localparam logic [2:0] CNT_ACC   = 3'd0;
  localparam logic [2:0] CNT_DROP  = 3'd1;
  localparam logic [2:0] CNT_REJ   = 3'd2;
  localparam logic [2:0] CNT_ESTOP = 3'd3;
  localparam logic [2:0] CNT_HOLD  = 3'd4;
  localparam logic [2:0] CNT_RELAX = 3'd5;
  localparam logic [2:0] CNT_TICK  = 3'd6;

  typedef struct packed {
    logic [2:0]           mode;
    logic [TIME_W-1:0]    now_ms;
    logic [SEQ_W-1:0]     in_seq;
    logic [PAYLOAD_W-1:0] in_payload;
    logic                 in_estop;
    logic [2:0]           counter_select;
  } item_t;

  typedef struct packed {
    logic                 post_ok;
    logic [1:0]           link_state;
    logic                 state_changed;
    logic                 out_valid;
    logic [SEQ_W-1:0]     out_seq;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 out_estop;
    logic [CNT_W-1:0]     counter_value;
    logic [TIME_W-1:0]    age_ms;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] short_timeout_ms;
    logic [TIME_W-1:0] long_timeout_ms;
  } cfg_t;

endpackage

### rtl/cmlw_if.sv
// Valid/ready channel interfaces for mailbox events and results.
interface cmlw_in_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         mode;
  logic [cmlw_pkg::TIME_W-1:0]        now_ms;
  logic [cmlw_pkg::SEQ_W-1:0]         in_seq;
  logic [cmlw_pkg::PAYLOAD_W-1:0]     in_payload;
  logic                               in_estop;
  logic [2:0]                         counter_select;

  modport source (
    output valid, mode, now_ms, in_seq, in_payload, in_estop, counter_select,
    input  ready
  );
  modport sink (
    input  valid, mode, now_ms, in_seq, in_payload, in_estop, counter_select,
    output ready
  );
endinterface

interface cmlw_out_if;
  logic                               valid;
  logic                               ready;
  logic                               post_ok;
  logic [1:0]                         link_state;
  logic                               state_changed;
  logic                               out_valid;
  logic [cmlw_pkg::SEQ_W-1:0]         out_seq;
  logic [cmlw_pkg::PAYLOAD_W-1:0]     out_payload;
  logic                               out_estop;
  logic [cmlw_pkg::CNT_W-1:0]         counter_value;
  logic [cmlw_pkg::TIME_W-1:0]        age_ms;

  modport source (
    output valid, post_ok, link_state, state_changed, out_valid, out_seq,
           out_payload, out_estop, counter_value, age_ms,
    input  ready
  );
  modport sink (
    input  valid, post_ok, link_state, state_changed, out_valid, out_seq,
           out_payload, out_estop, counter_value, age_ms,
    output ready
  );
endinterface

### rtl/command_mailbox_liveness_watchdog.sv
// Top level of the command mailbox liveness watchdog: input register, core and result register.
// Each event transaction is taken into an input register, evaluated against the mailbox state
// by one pass of logic (a serial sequence compare, one age subtract and two timeout compares)
// and written to a result register. The result is presented on the output from that register,
// after the event has passed from the input register through the core into the result register.
// A new transaction is accepted in every cycle, so the sustained rate is one event per clock
// while the result side keeps taking results; a stalled result holds the input register, and
// the input side stalls only when both registers are full. Timeouts may be written through the
// configuration port only while no event is in flight.
module command_mailbox_liveness_watchdog #(
  parameter int unsigned PayloadBits = cmlw_pkg::PAYLOAD_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cmlw_in_if.sink                             in_i,
  cmlw_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [cmlw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cmlw_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  cmlw_pkg::cfg_t    cfg_q;
  cmlw_pkg::item_t   item_q;
  logic              item_valid_q;
  cmlw_pkg::result_t res_d;
  cmlw_pkg::result_t res_q;
  logic              res_valid_q;
  logic              advance;
  logic              in_fire;

  assign advance    = item_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_timeout_ms <= cmlw_pkg::SHORT_TIMEOUT_RST;
      cfg_q.long_timeout_ms  <= cmlw_pkg::LONG_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cmlw_pkg::CFG_SHORT: cfg_q.short_timeout_ms <= cfg_data_i;
        cmlw_pkg::CFG_LONG:  cfg_q.long_timeout_ms  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= in_fire || (item_valid_q && !advance);
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.mode           <= in_i.mode;
      item_q.now_ms         <= in_i.now_ms;
      item_q.in_seq         <= in_i.in_seq;
      item_q.in_payload     <= in_i.in_payload;
      item_q.in_estop       <= in_i.in_estop;
      item_q.counter_select <= in_i.counter_select;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  cmlw_core #(
    .PayloadBits (PayloadBits)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg_q),
    .res_o     (res_d)
  );

  assign out_o.valid         = res_valid_q;
  assign out_o.post_ok       = res_q.post_ok;
  assign out_o.link_state    = res_q.link_state;
  assign out_o.state_changed = res_q.state_changed;
  assign out_o.out_valid     = res_q.out_valid;
  assign out_o.out_seq       = res_q.out_seq;
  assign out_o.out_payload   = res_q.out_payload;
  assign out_o.out_estop     = res_q.out_estop;
  assign out_o.counter_value = res_q.counter_value;
  assign out_o.age_ms        = res_q.age_ms;

`ifndef SYNTHESIS
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !advance |=> item_valid_q)
    else $error("pending event dropped from the input register");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("evaluated event produced no result");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !out_o.ready |-> !advance)
    else $error("result register overwritten while stalled");
`endif

endmodule

### rtl/cmlw_core.sv
// Mailbox slot, estop latch, link state and event counters with the per-event logic.
module cmlw_core #(
  parameter int unsigned PayloadBits = cmlw_pkg::PAYLOAD_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_en_i,
  input  cmlw_pkg::item_t item_i,
  input  cmlw_pkg::cfg_t  cfg_i,
  output cmlw_pkg::result_t res_o
);

  logic                           slot_valid_q;
  logic [cmlw_pkg::SEQ_W-1:0]     slot_seq_q;
  logic [cmlw_pkg::TIME_W-1:0]    slot_time_q;
  logic [PayloadBits-1:0]         slot_payload_q;
  logic                           slot_estop_q;
  logic                           estop_q;
  logic [1:0]                     prev_state_q;
  logic [cmlw_pkg::CNT_W-1:0]     cnt_q [cmlw_pkg::NUM_CNT];

  logic [cmlw_pkg::SEQ_W-1:0]     seq_diff;
  logic                           newer;
  logic                           post_accept;
  logic [cmlw_pkg::TIME_W-1:0]    age_pre;
  logic [1:0]                     tick_state;
  logic                           state_change;
  logic [cmlw_pkg::NUM_CNT-1:0]   cnt_inc;
  logic                           is_post;
  logic                           is_tick;
  logic                           latch_req;

  assign is_post = item_i.mode == cmlw_pkg::MODE_POST;
  assign is_tick = item_i.mode == cmlw_pkg::MODE_TICK;
  assign latch_req = item_i.mode == cmlw_pkg::MODE_LATCH && item_i.in_estop;

  // Serial number arithmetic: newer when the forward distance is in 1 .. 2^31-1.
  assign seq_diff    = item_i.in_seq - slot_seq_q;
  assign newer       = (seq_diff != '0) && !seq_diff[cmlw_pkg::SEQ_W-1];
  assign post_accept = !slot_valid_q || newer;
  assign age_pre     = item_i.now_ms - slot_time_q;

  always_comb begin
    if (estop_q) begin
      tick_state = cmlw_pkg::ST_RELAX;
    end else if (!slot_valid_q) begin
      tick_state = cmlw_pkg::ST_IDLE;
    end else if (age_pre <= cfg_i.short_timeout_ms) begin
      tick_state = cmlw_pkg::ST_FRESH;
    end else if (age_pre <= cfg_i.long_timeout_ms) begin
      tick_state = cmlw_pkg::ST_HOLD;
    end else begin
      tick_state = cmlw_pkg::ST_RELAX;
    end
  end

  assign state_change = is_tick && (tick_state != prev_state_q);

  always_comb begin
    cnt_inc = '0;
    cnt_inc[cmlw_pkg::CNT_ACC]   = is_post && post_accept;
    cnt_inc[cmlw_pkg::CNT_DROP]  = is_post && !post_accept;
    cnt_inc[cmlw_pkg::CNT_REJ]   = item_i.mode == cmlw_pkg::MODE_REJECT;
    cnt_inc[cmlw_pkg::CNT_ESTOP] = (is_post && post_accept && item_i.in_estop) || latch_req;
    cnt_inc[cmlw_pkg::CNT_HOLD]  = state_change && tick_state == cmlw_pkg::ST_HOLD;
    cnt_inc[cmlw_pkg::CNT_RELAX] = state_change && tick_state == cmlw_pkg::ST_RELAX;
    cnt_inc[cmlw_pkg::CNT_TICK]  = is_tick;
  end

  always_comb begin
    res_o = '0;
    res_o.post_ok = is_post && post_accept;
    if (is_tick) begin
      res_o.link_state    = tick_state;
      res_o.state_changed = state_change;
      res_o.out_valid     = estop_q || slot_valid_q;
      if (estop_q) begin
        res_o.out_seq   = slot_seq_q;
        res_o.out_estop = 1'b1;
      end else if (slot_valid_q) begin
        res_o.out_seq     = slot_seq_q;
        res_o.out_payload = cmlw_pkg::PAYLOAD_W'(slot_payload_q);
        res_o.out_estop   = slot_estop_q;
      end
    end
    if (item_i.mode == cmlw_pkg::MODE_READ &&
        item_i.counter_select < 3'(cmlw_pkg::NUM_CNT)) begin
      res_o.counter_value = cnt_q[item_i.counter_select];
    end
    // An accepted post sets the arrival time to now, so its age is zero.
    if (is_post && post_accept) begin
      res_o.age_ms = '0;
    end else if (slot_valid_q) begin
      res_o.age_ms = age_pre;
    end else begin
      res_o.age_ms = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
      estop_q      <= 1'b0;
      prev_state_q <= cmlw_pkg::ST_IDLE;
      slot_seq_q   <= '0;
      slot_time_q  <= '0;
      slot_estop_q <= 1'b0;
      cnt_q        <= '{default: '0};
    end else if (step_en_i) begin
      if (is_post && post_accept) begin
        slot_valid_q <= 1'b1;
        slot_seq_q   <= item_i.in_seq;
        slot_time_q  <= item_i.now_ms;
        slot_estop_q <= item_i.in_estop;
      end
      if ((is_post && post_accept && item_i.in_estop) || latch_req) begin
        estop_q <= 1'b1;
      end else if (item_i.mode == cmlw_pkg::MODE_CLEAR) begin
        estop_q <= 1'b0;
      end
      if (state_change) begin
        prev_state_q <= tick_state;
      end
      for (int i = 0; i < cmlw_pkg::NUM_CNT; i++) begin
        if (cnt_inc[i]) begin
          cnt_q[i] <= cnt_q[i] + 1'b1;
        end
      end
    end
  end

  // The payload is a data register with its own reset, loaded only by an accepted post.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_payload_q <= '0;
    end else if (step_en_i && is_post && post_accept) begin
      slot_payload_q <= item_i.in_payload[PayloadBits-1:0];
    end
  end

`ifndef SYNTHESIS
  a_post_fills_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res_o.post_ok |=> slot_valid_q && slot_seq_q == $past(item_i.in_seq))
    else $error("accepted post did not fill the slot");

  a_latch_sets_estop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && latch_req |=> estop_q)
    else $error("estop latch request was lost");

  a_state_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res_o.state_changed |=> prev_state_q == $past(res_o.link_state))
    else $error("previous state not updated on a state change");

  a_estop_relax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_tick && estop_q |-> res_o.link_state == cmlw_pkg::ST_RELAX && res_o.out_payload == '0)
    else $error("latched estop did not force relax with a zeroed command");
`endif

endmodule

### test/command_mailbox_liveness_watchdog_tb.sv
// Self-checking testbench for the command mailbox liveness watchdog.
`timescale 1ns / 1ps

module command_mailbox_liveness_watchdog_tb;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [cmlw_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [cmlw_pkg::CFG_DATA_W-1:0] cfg_data_i;

  cmlw_in_if in_ch ();
  cmlw_out_if out_ch ();

  command_mailbox_liveness_watchdog dut (
    .clk_i,
    .rst_ni,
    .in_i(in_ch),
    .out_o(out_ch),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  // Mailbox state as the testbench expects it to be.
  logic [cmlw_pkg::TIME_W-1:0] short_lim = cmlw_pkg::SHORT_TIMEOUT_RST;
  logic [cmlw_pkg::TIME_W-1:0] long_lim = cmlw_pkg::LONG_TIMEOUT_RST;
  logic mb_valid = 1'b0;
  logic [cmlw_pkg::SEQ_W-1:0] mb_seq = '0;
  logic [cmlw_pkg::TIME_W-1:0] mb_time = '0;
  logic [cmlw_pkg::PAYLOAD_W-1:0] mb_payload = '0;
  logic mb_estop = 1'b0;
  logic estop_hold = 1'b0;
  logic [1:0] last_link = cmlw_pkg::ST_IDLE;
  logic [cmlw_pkg::CNT_W-1:0] evt_cnt [cmlw_pkg::NUM_CNT];

  cmlw_pkg::item_t pending_events[$];
  cmlw_pkg::result_t expected_results[$];
  cmlw_pkg::item_t live_item;
  int unsigned sent_cnt = 0;
  int unsigned mismatches = 0;

  // Generator view of the mailbox, used only to aim the stimulus.
  logic [cmlw_pkg::SEQ_W-1:0] gen_seq;
  logic [cmlw_pkg::TIME_W-1:0] gen_time;
  logic [cmlw_pkg::TIME_W-1:0] gen_now;

  // Neither side stalls while this window of transactions goes through.
  wire calm = (sent_cnt >= 700) && (sent_cnt < 1100);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void bump_count(logic [2:0] idx);
    evt_cnt[idx] = evt_cnt[idx] + 1'b1;
  endfunction

  function automatic cmlw_pkg::result_t mailbox_predict(cmlw_pkg::item_t ev);
    cmlw_pkg::result_t r;
    logic [1:0] link;
    logic [cmlw_pkg::SEQ_W-1:0] diff;
    logic [cmlw_pkg::TIME_W-1:0] age;
    logic [cmlw_pkg::PAYLOAD_W-1:0] keep_mask;
    r = '0;
    keep_mask = {cmlw_pkg::PAYLOAD_W{1'b1}} >> (cmlw_pkg::PAYLOAD_W - cmlw_pkg::PAYLOAD_BITS);
    case (ev.mode)
      cmlw_pkg::MODE_POST: begin
        diff = ev.in_seq - mb_seq;
        // Newer means a serial distance of 1 .. 2^31-1.
        if (mb_valid && !(diff != '0 && !diff[cmlw_pkg::SEQ_W-1])) begin
          bump_count(cmlw_pkg::CNT_DROP);
        end else begin
          mb_valid = 1'b1;
          mb_seq = ev.in_seq;
          mb_time = ev.now_ms;
          mb_payload = ev.in_payload & keep_mask;
          mb_estop = ev.in_estop;
          bump_count(cmlw_pkg::CNT_ACC);
          if (ev.in_estop) begin
            estop_hold = 1'b1;
            bump_count(cmlw_pkg::CNT_ESTOP);
          end
          r.post_ok = 1'b1;
        end
      end
      cmlw_pkg::MODE_TICK: begin
        bump_count(cmlw_pkg::CNT_TICK);
        age = ev.now_ms - mb_time;
        if (!mb_valid) link = cmlw_pkg::ST_IDLE;
        else if (age <= short_lim) link = cmlw_pkg::ST_FRESH;
        else if (age <= long_lim) link = cmlw_pkg::ST_HOLD;
        else link = cmlw_pkg::ST_RELAX;
        if (estop_hold) link = cmlw_pkg::ST_RELAX;
        if (link != last_link) begin
          if (link == cmlw_pkg::ST_HOLD) bump_count(cmlw_pkg::CNT_HOLD);
          else if (link == cmlw_pkg::ST_RELAX) bump_count(cmlw_pkg::CNT_RELAX);
          last_link = link;
          r.state_changed = 1'b1;
        end
        r.link_state = link;
        if (estop_hold) begin
          r.out_valid = 1'b1;
          r.out_seq = mb_seq;
          r.out_estop = 1'b1;
        end else if (mb_valid) begin
          r.out_valid = 1'b1;
          r.out_seq = mb_seq;
          r.out_payload = mb_payload;
          r.out_estop = mb_estop;
        end
      end
      cmlw_pkg::MODE_REJECT: bump_count(cmlw_pkg::CNT_REJ);
      cmlw_pkg::MODE_LATCH: begin
        if (ev.in_estop) begin
          estop_hold = 1'b1;
          bump_count(cmlw_pkg::CNT_ESTOP);
        end
      end
      cmlw_pkg::MODE_CLEAR: estop_hold = 1'b0;
      cmlw_pkg::MODE_READ: begin
        if (ev.counter_select < cmlw_pkg::NUM_CNT) begin
          r.counter_value = evt_cnt[ev.counter_select];
        end
      end
      default: ;
    endcase
    r.age_ms = mb_valid ? ev.now_ms - mb_time : '1;
    return r;
  endfunction

  function automatic cmlw_pkg::item_t make_event(logic [2:0] mode,
                                                 logic [cmlw_pkg::TIME_W-1:0] now,
                                                 logic [cmlw_pkg::SEQ_W-1:0] seq,
                                                 logic [cmlw_pkg::PAYLOAD_W-1:0] payload,
                                                 logic estop, logic [2:0] sel);
    cmlw_pkg::item_t ev;
    ev.mode = mode;
    ev.now_ms = now;
    ev.in_seq = seq;
    ev.in_payload = payload;
    ev.in_estop = estop;
    ev.counter_select = sel;
    return ev;
  endfunction

  task automatic add_random_events(int unsigned count);
    int unsigned pick;
    int unsigned how;
    logic [cmlw_pkg::SEQ_W-1:0] seq;
    logic [cmlw_pkg::TIME_W-1:0] now;
    logic [cmlw_pkg::TIME_W-1:0] offset;
    logic [cmlw_pkg::PAYLOAD_W-1:0] payload;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      how = $urandom_range(99);
      payload = {$urandom, $urandom};
      if (pick < 35) begin
        gen_now = gen_now + $urandom_range(50);
        now = (how % 20 == 0) ? $urandom : gen_now;
        if (how < 70) seq = gen_seq + $urandom_range(1, 5);
        else if (how < 80) seq = gen_seq;
        else if (how < 90) seq = gen_seq - $urandom_range(1, 1000);
        else if (how < 95) seq = gen_seq + 32'h8000_0000;
        else seq = $urandom;
        if (how < 70 || how >= 95) begin
          gen_seq = seq;
          gen_time = now;
        end
        pending_events.push_back(make_event(cmlw_pkg::MODE_POST, now, seq, payload,
                                            $urandom_range(99) < 5, 3'($urandom_range(7))));
      end else if (pick < 70) begin
        // Aim half of the ticks at the timeout boundaries.
        case (how % 8)
          0: offset = short_lim;
          1: offset = short_lim + 1'b1;
          2: offset = long_lim;
          3: offset = long_lim + 1'b1;
          4: offset = '0;
          5: offset = $urandom;
          default: offset = $urandom_range(1500);
        endcase
        pending_events.push_back(make_event(cmlw_pkg::MODE_TICK, gen_time + offset, $urandom,
                                            payload, 1'($urandom_range(1)),
                                            3'($urandom_range(7))));
      end else if (pick < 76) begin
        pending_events.push_back(make_event(cmlw_pkg::MODE_REJECT, gen_now, $urandom, payload,
                                            1'($urandom_range(1)), 3'($urandom_range(7))));
      end else if (pick < 81) begin
        pending_events.push_back(make_event(cmlw_pkg::MODE_LATCH, gen_now, $urandom, payload,
                                            1'($urandom_range(1)), 3'($urandom_range(7))));
      end else if (pick < 89) begin
        pending_events.push_back(make_event(cmlw_pkg::MODE_CLEAR, gen_now, $urandom, payload,
                                            1'($urandom_range(1)), 3'($urandom_range(7))));
      end else if (pick < 97) begin
        pending_events.push_back(make_event(cmlw_pkg::MODE_READ, gen_now, $urandom, payload,
                                            1'($urandom_range(1)), 3'($urandom_range(7))));
      end else begin
        pending_events.push_back(make_event(3'($urandom_range(6, 7)), gen_now, $urandom,
                                            payload, 1'($urandom_range(1)),
                                            3'($urandom_range(7))));
      end
    end
  endtask

  task automatic write_timeout(logic [cmlw_pkg::CFG_IDX_W-1:0] idx,
                               logic [cmlw_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == cmlw_pkg::CFG_SHORT) short_lim = value;
    else long_lim = value;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_events.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: presents queued events and records each accepted transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= cmlw_pkg::MODE_POST;
      in_ch.now_ms <= '0;
      in_ch.in_seq <= '0;
      in_ch.in_payload <= '0;
      in_ch.in_estop <= 1'b0;
      in_ch.counter_select <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(mailbox_predict(live_item));
        sent_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_events.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
          live_item = pending_events.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= live_item.mode;
          in_ch.now_ms <= live_item.now_ms;
          in_ch.in_seq <= live_item.in_seq;
          in_ch.in_payload <= live_item.in_payload;
          in_ch.in_estop <= live_item.in_estop;
          in_ch.counter_select <= live_item.counter_select;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transaction against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    cmlw_pkg::result_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual age %h", $time,
                   out_ch.age_ms);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("post_ok", 64'(want.post_ok), 64'(out_ch.post_ok));
          check_field("link_state", 64'(want.link_state), 64'(out_ch.link_state));
          check_field("state_changed", 64'(want.state_changed), 64'(out_ch.state_changed));
          check_field("out_valid", 64'(want.out_valid), 64'(out_ch.out_valid));
          check_field("out_seq", 64'(want.out_seq), 64'(out_ch.out_seq));
          check_field("out_payload", want.out_payload, out_ch.out_payload);
          check_field("out_estop", 64'(want.out_estop), 64'(out_ch.out_estop));
          check_field("counter_value", 64'(want.counter_value), 64'(out_ch.counter_value));
          check_field("age_ms", 64'(want.age_ms), 64'(out_ch.age_ms));
        end
      end
      out_ch.ready <= calm || $urandom_range(99) >= 21;
    end
  end

  initial begin
    logic [cmlw_pkg::TIME_W-1:0] short_set [6];
    logic [cmlw_pkg::TIME_W-1:0] long_set [6];
    for (int i = 0; i < cmlw_pkg::NUM_CNT; i++) evt_cnt[i] = '0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset timeouts of 200 and 1200 ms.
    pending_events.push_back(make_event(cmlw_pkg::MODE_READ, 32'd0, 32'd0, 64'd0, 1'b0, 3'd7));
    pending_events.push_back(make_event(cmlw_pkg::MODE_TICK, 32'd0, 32'd0, 64'd0, 1'b0, 3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_POST, 32'hFFFF_FFF0, 32'hFFFF_FFFF, '1,
                                        1'b0, 3'd0));
    // Sequence zero is newer than all ones across the wrap.
    pending_events.push_back(make_event(cmlw_pkg::MODE_POST, 32'd8, 32'd0, 64'd0, 1'b0, 3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_POST, 32'd9, 32'd0, 64'h1, 1'b0, 3'd0));
    // A distance of exactly half the sequence space counts as older.
    pending_events.push_back(make_event(cmlw_pkg::MODE_POST, 32'd10, 32'h8000_0000, 64'h2,
                                        1'b1, 3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_POST, 32'd100, 32'h7FFF_FFFF,
                                        64'h5A5A_A5A5_0F0F_F0F0, 1'b0, 3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_TICK, 32'd300, 32'd0, 64'd0, 1'b0, 3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_TICK, 32'd301, 32'd0, 64'd0, 1'b0, 3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_TICK, 32'd1300, 32'd0, 64'd0, 1'b0,
                                        3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_TICK, 32'd1301, 32'd0, 64'd0, 1'b0,
                                        3'd0));
    // A latch request of zero leaves the estop clear.
    pending_events.push_back(make_event(cmlw_pkg::MODE_LATCH, 32'd100, 32'd0, 64'd0, 1'b0,
                                        3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_TICK, 32'd100, 32'd0, 64'd0, 1'b0, 3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_LATCH, 32'd100, 32'd0, 64'd0, 1'b1,
                                        3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_TICK, 32'd100, 32'd0, 64'd0, 1'b0, 3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_POST, 32'd200, 32'h8000_0000, '1, 1'b1,
                                        3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_CLEAR, 32'd200, 32'd0, 64'd0, 1'b0,
                                        3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_TICK, 32'd200, 32'd0, 64'd0, 1'b0, 3'd0));
    pending_events.push_back(make_event(cmlw_pkg::MODE_REJECT, 32'd200, 32'd0, 64'd0, 1'b0,
                                        3'd0));
    pending_events.push_back(make_event(3'd6, 32'd200, '1, '1, 1'b1, 3'd7));
    pending_events.push_back(make_event(3'd7, 32'd200, '1, '1, 1'b1, 3'd7));
    pending_events.push_back(make_event(cmlw_pkg::MODE_READ, 32'd200, 32'd0, 64'd0, 1'b0,
                                        cmlw_pkg::CNT_ACC));
    pending_events.push_back(make_event(cmlw_pkg::MODE_READ, 32'd200, 32'd0, 64'd0, 1'b0,
                                        cmlw_pkg::CNT_ESTOP));
    pending_events.push_back(make_event(cmlw_pkg::MODE_READ, 32'd200, 32'd0, 64'd0, 1'b0,
                                        cmlw_pkg::CNT_TICK));
    gen_seq = 32'h8000_0000;
    gen_time = 32'd200;
    gen_now = 32'd200;

    short_set[0] = 32'd1;        long_set[0] = 32'd2;
    short_set[1] = '1;           long_set[1] = '1;
    short_set[2] = 32'd1;        long_set[2] = '1;
    short_set[3] = 32'd500;      long_set[3] = 32'd40;
    short_set[4] = $urandom_range(1, 300);
    long_set[4] = short_set[4] + $urandom_range(1, 900);
    short_set[5] = cmlw_pkg::SHORT_TIMEOUT_RST;
    long_set[5] = cmlw_pkg::LONG_TIMEOUT_RST;

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_timeout(cmlw_pkg::CFG_SHORT, short_set[p]);
      write_timeout(cmlw_pkg::CFG_LONG, long_set[p]);
      @(negedge clk_i);
      add_random_events(292);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### command_mailbox_liveness_watchdog.f
rtl/cmlw_pkg.sv
rtl/cmlw_if.sv
rtl/cmlw_core.sv
rtl/command_mailbox_liveness_watchdog.sv
test/command_mailbox_liveness_watchdog_tb.sv
